// ===== rtl/core/rectangle_outline_overlay_top_assert.svh =====
// Assertion macros for the outline overlay checker
`ifndef RECTANGLE_OUTLINE_OVERLAY_TOP_ASSERT_SVH
`define RECTANGLE_OUTLINE_OVERLAY_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define ROO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define ROO_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/roo_pkg.sv =====
// Shared types and constants for the rectangle outline overlay
package roo_pkg;

  localparam int unsigned MAX_DIM = 4096;
  localparam int unsigned REG_W   = 13;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned PIX_W   = 24;
  localparam int unsigned IDX_W   = 3;

  typedef enum logic [IDX_W-1:0] {
    IDX_LEFT_X    = 3'd0,
    IDX_LOW_Y     = 3'd1,
    IDX_RIGHT_X   = 3'd2,
    IDX_HIGH_Y    = 3'd3,
    IDX_THICKNESS = 3'd4,
    IDX_COLOR     = 3'd5,
    IDX_WIDTH     = 3'd6,
    IDX_HEIGHT    = 3'd7
  } cfg_idx_t;

  // Band edges derived from the registers; ends are exclusive
  typedef struct packed {
    logic [REG_W-1:0] left_x;
    logic [REG_W-1:0] right_x;
    logic [REG_W-1:0] low_y;
    logic [REG_W-1:0] high_y;
    logic [REG_W-1:0] width;
    logic [REG_W-1:0] height;
    logic [REG_W-1:0] row_b_lo;
    logic [REG_W-1:0] row_b_hi;
    logic [REG_W-1:0] row_t_lo;
    logic [REG_W-1:0] row_t_hi;
    logic [REG_W-1:0] col_l_lo;
    logic [REG_W-1:0] col_l_hi;
    logic [REG_W-1:0] col_r_lo;
    logic [REG_W-1:0] col_r_hi;
    logic [REG_W-1:0] sq_l_hi;
    logic [REG_W-1:0] sq_r_hi;
    logic             rect_ok;
  } bounds_t;

  // Compare results of one pixel against the bounds
  typedef struct packed {
    logic in_img;
    logic x_span;
    logic y_span;
    logic row_b;
    logic row_t;
    logic col_l;
    logic col_r;
    logic sq_l;
    logic sq_r;
  } hits_t;

endpackage

// ===== rtl/core/rectangle_outline_overlay_top.sv =====
// Top level of the rectangle outline overlay
//
//  channel  | ports                                    | handshake
//  ---------+------------------------------------------+----------------------
//  input    | in_pixel_x, in_pixel_y, in_pixel_in      | start & !busy
//  result   | out_pixel_out, out_on_outline            | out_strobe, one cycle
//  config   | cfg_index, cfg_data                      | cfg_valid & cfg_ready
//
// One pixel per clock; a beat taken passes through the capture, compare and select
// registers on its way to the result ports.
// Band edges are registered from the config registers, ahead of the compares.
// busy and !cfg_ready are high during reset; config and control registers return to reset values.
// Results cannot be held off, so busy never rises after reset.
module rectangle_outline_overlay_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [roo_pkg::COORD_W-1:0]   in_pixel_x,
  input  logic [roo_pkg::COORD_W-1:0]   in_pixel_y,
  input  logic [roo_pkg::PIX_W-1:0]     in_pixel_in,
  output logic                          out_strobe,
  output logic [roo_pkg::PIX_W-1:0]     out_pixel_out,
  output logic                          out_on_outline,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [roo_pkg::IDX_W-1:0]     cfg_index,
  input  logic [roo_pkg::PIX_W-1:0]     cfg_data
);

  roo_pkg::bounds_t            bounds;
  logic [roo_pkg::PIX_W-1:0]   draw_color;

  roo_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .bounds     (bounds),
    .draw_color (draw_color)
  );

  roo_pipe u_pipe (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_pixel_x     (in_pixel_x),
    .in_pixel_y     (in_pixel_y),
    .in_pixel_in    (in_pixel_in),
    .bounds         (bounds),
    .draw_color     (draw_color),
    .out_strobe     (out_strobe),
    .out_pixel_out  (out_pixel_out),
    .out_on_outline (out_on_outline)
  );

endmodule

// ===== rtl/core/roo_cfg_regs.sv =====
// Configuration registers and precomputed band edges
module roo_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [roo_pkg::IDX_W-1:0]        cfg_index,
  input  logic [roo_pkg::PIX_W-1:0]        cfg_data,
  output roo_pkg::bounds_t                 bounds,
  output logic [roo_pkg::PIX_W-1:0]        draw_color
);

  localparam int unsigned RW = roo_pkg::REG_W;

  logic          ready_r;
  logic [RW-1:0] left_x_r, low_y_r, right_x_r, high_y_r;
  logic [RW-1:0] thick_r, width_r, height_r;
  logic [roo_pkg::PIX_W-1:0] color_r;
  roo_pkg::bounds_t bounds_r, bounds_nxt;
  logic          wr_en;
  logic [RW-1:0] wr_val;
  logic [RW-1:0] half_t;
  logic [RW-1:0] w_lim, h_lim;

  // near edge: c - min(t/2, c)
  function automatic logic [RW-1:0] band_lo(input logic [RW-1:0] c,
                                            input logic [RW-1:0] h);
    logic [RW-1:0] m;
    begin
      m = (h < c) ? h : c;
      band_lo = c - m;
    end
  endfunction

  // far edge: min(lo + t, limit)
  function automatic logic [RW-1:0] band_hi(input logic [RW-1:0] lo,
                                            input logic [RW-1:0] t,
                                            input logic [RW-1:0] lim);
    logic [RW:0] sum;
    begin
      sum     = {1'b0, lo} + {1'b0, t};
      band_hi = (sum < {1'b0, lim}) ? sum[RW-1:0] : lim;
    end
  endfunction

  assign wr_en     = cfg_valid && ready_r;
  assign wr_val    = cfg_data[RW-1:0];
  assign cfg_ready = ready_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r   <= 1'b0;
      left_x_r  <= '0;
      low_y_r   <= '0;
      right_x_r <= '0;
      high_y_r  <= '0;
      thick_r   <= RW'(1);
      color_r   <= '0;
      width_r   <= RW'(roo_pkg::MAX_DIM);
      height_r  <= RW'(roo_pkg::MAX_DIM);
    end else begin
      ready_r <= 1'b1;
      if (wr_en) begin
        case (roo_pkg::cfg_idx_t'(cfg_index))
          roo_pkg::IDX_LEFT_X:    left_x_r  <= wr_val;
          roo_pkg::IDX_LOW_Y:     low_y_r   <= wr_val;
          roo_pkg::IDX_RIGHT_X:   right_x_r <= wr_val;
          roo_pkg::IDX_HIGH_Y:    high_y_r  <= wr_val;
          roo_pkg::IDX_THICKNESS: thick_r   <= wr_val;
          roo_pkg::IDX_COLOR:     color_r   <= cfg_data;
          roo_pkg::IDX_WIDTH:     width_r   <= wr_val;
          roo_pkg::IDX_HEIGHT:    height_r  <= wr_val;
          default: ;
        endcase
      end
    end
  end

  assign half_t = {1'b0, thick_r[RW-1:1]};
  // zero width/height wraps here, but such pixels are rejected as outside
  assign w_lim  = width_r - RW'(1);
  assign h_lim  = height_r - RW'(1);

  always_comb begin
    bounds_nxt.left_x   = left_x_r;
    bounds_nxt.right_x  = right_x_r;
    bounds_nxt.low_y    = low_y_r;
    bounds_nxt.high_y   = high_y_r;
    bounds_nxt.width    = width_r;
    bounds_nxt.height   = height_r;
    bounds_nxt.row_b_lo = band_lo(low_y_r, half_t);
    bounds_nxt.row_t_lo = band_lo(high_y_r, half_t);
    bounds_nxt.col_l_lo = band_lo(left_x_r, half_t);
    bounds_nxt.col_r_lo = band_lo(right_x_r, half_t);
    bounds_nxt.row_b_hi = band_hi(bounds_nxt.row_b_lo, thick_r, h_lim);
    bounds_nxt.row_t_hi = band_hi(bounds_nxt.row_t_lo, thick_r, h_lim);
    bounds_nxt.col_l_hi = band_hi(bounds_nxt.col_l_lo, thick_r, w_lim);
    bounds_nxt.col_r_hi = band_hi(bounds_nxt.col_r_lo, thick_r, w_lim);
    // corner squares run one column further than the side bands
    bounds_nxt.sq_l_hi  = band_hi(bounds_nxt.col_l_lo, thick_r, width_r);
    bounds_nxt.sq_r_hi  = band_hi(bounds_nxt.col_r_lo, thick_r, width_r);
    bounds_nxt.rect_ok  = (left_x_r <= right_x_r) && (low_y_r <= high_y_r) &&
                          (right_x_r <= width_r) && (high_y_r <= height_r);
  end

  always_ff @(posedge clk) begin
    bounds_r <= bounds_nxt;
  end

  assign bounds     = bounds_r;
  assign draw_color = color_r;

endmodule

// ===== rtl/core/roo_pipe.sv =====
// Three-stage pixel pipeline: capture, compare, combine and select
module roo_pipe (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [roo_pkg::COORD_W-1:0]   in_pixel_x,
  input  logic [roo_pkg::COORD_W-1:0]   in_pixel_y,
  input  logic [roo_pkg::PIX_W-1:0]     in_pixel_in,
  input  roo_pkg::bounds_t              bounds,
  input  logic [roo_pkg::PIX_W-1:0]     draw_color,
  output logic                          out_strobe,
  output logic [roo_pkg::PIX_W-1:0]     out_pixel_out,
  output logic                          out_on_outline
);

  localparam int unsigned RW = roo_pkg::REG_W;

  logic                        busy_r;
  logic                        s1_vld_r, s2_vld_r, s3_vld_r;
  logic [roo_pkg::COORD_W-1:0] s1_x_r, s1_y_r;
  logic [roo_pkg::PIX_W-1:0]   s1_pix_r, s2_pix_r, s3_pix_r;
  roo_pkg::hits_t              hits_nxt, s2_hits_r;
  logic                        s3_on_r, on_nxt;
  logic [RW-1:0]               xe, ye;
  logic                        accept;

  assign accept = start && !busy_r;
  assign xe     = {1'b0, s1_x_r};
  assign ye     = {1'b0, s1_y_r};

  // held high through reset only; the pipeline never stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s3_on_r  <= 1'b0;
    end else begin
      busy_r   <= 1'b0;
      s1_vld_r <= accept;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s3_on_r  <= s2_vld_r && on_nxt;
    end
  end

  always_comb begin
    hits_nxt.in_img = (xe < bounds.width) && (ye < bounds.height);
    hits_nxt.x_span = (xe >= bounds.left_x) && (xe <= bounds.right_x);
    hits_nxt.y_span = (ye >= bounds.low_y) && (ye <= bounds.high_y);
    hits_nxt.row_b  = (ye >= bounds.row_b_lo) && (ye < bounds.row_b_hi);
    hits_nxt.row_t  = (ye >= bounds.row_t_lo) && (ye < bounds.row_t_hi);
    hits_nxt.col_l  = (xe >= bounds.col_l_lo) && (xe < bounds.col_l_hi);
    hits_nxt.col_r  = (xe >= bounds.col_r_lo) && (xe < bounds.col_r_hi);
    hits_nxt.sq_l   = (xe >= bounds.col_l_lo) && (xe < bounds.sq_l_hi);
    hits_nxt.sq_r   = (xe >= bounds.col_r_lo) && (xe < bounds.sq_r_hi);
  end

  // sides, then the four corner squares
  assign on_nxt = bounds.rect_ok && s2_hits_r.in_img &&
                  ((s2_hits_r.x_span && (s2_hits_r.row_b || s2_hits_r.row_t)) ||
                   (s2_hits_r.y_span && (s2_hits_r.col_l || s2_hits_r.col_r)) ||
                   ((s2_hits_r.row_b || s2_hits_r.row_t) &&
                    (s2_hits_r.sq_l || s2_hits_r.sq_r)));

  always_ff @(posedge clk) begin
    s1_x_r    <= in_pixel_x;
    s1_y_r    <= in_pixel_y;
    s1_pix_r  <= in_pixel_in;
    s2_hits_r <= hits_nxt;
    s2_pix_r  <= s1_pix_r;
    s3_pix_r  <= on_nxt ? draw_color : s2_pix_r;
  end

  assign busy           = busy_r;
  assign out_strobe     = s3_vld_r;
  assign out_pixel_out  = s3_pix_r;
  assign out_on_outline = s3_on_r;

endmodule

// ===== rtl/core/roo_checker.sv =====
// Port-level checks for the outline overlay, bound to the top level
`include "rectangle_outline_overlay_top_assert.svh"

module roo_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input logic out_on_outline
);

  // every accepted beat comes out as a result, and no result appears without one
  `ROO_ASSERT_IMP(a_latency, start && !busy, ##3 out_strobe, "accepted beat lost")
  `ROO_ASSERT_IMP(a_no_extra, out_strobe, $past(start && !busy, 3), "result without beat")
  // the outline flag is only raised with a result
  `ROO_ASSERT_IMP(a_flag_qual, !out_strobe, !out_on_outline, "outline flag without strobe")
  // never busy once out of reset
  `ROO_ASSERT_NXT(a_no_stall, rst_n, !busy, "busy after reset")

endmodule

bind rectangle_outline_overlay_top roo_checker u_roo_checker (.*);
